// ===== design/hff_pkg.sv =====
// ----------------------------------------------------------------------------
// hff_pkg: shared types and constants for the hex field formatter
// Sequencer phases, request and character beat structs, ASCII codes and the
// hex digit to character conversion.
// ----------------------------------------------------------------------------
package hff_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SCAN,
    PH_SIZE,
    PH_PLAN,
    PH_LEAD,
    PH_PFX0,
    PH_PFX1,
    PH_DIGIT,
    PH_TRAIL
  } phase_t;

  // Length modes
  localparam logic [1:0] LEN_32   = 2'd0;
  localparam logic [1:0] LEN_16   = 2'd1;
  localparam logic [1:0] LEN_8    = 2'd2;
  localparam logic [1:0] LEN_FULL = 2'd3;

  // ASCII codes and digit offsets
  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] CHAR_ZERO      = 8'd48;
  localparam logic [7:0] CHAR_X_LOWER   = 8'd120;
  localparam logic [7:0] CHAR_X_UPPER   = 8'd88;
  localparam logic [7:0] CHAR_LOWER_OFS = 8'd87;
  localparam logic [7:0] CHAR_UPPER_OFS = 8'd55;

  // Input request width in tdata, before byte padding
  localparam int REQ_BITS  = 83;
  localparam int REQ_BYTES = (REQ_BITS + 7) / 8;

  // One conversion request
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  length_mode;
    logic        uppercase;
    logic        has_precision;
    logic [5:0]  precision;
    logic [5:0]  field_width;
    logic        hash_prefix;
    logic        zero_pad;
    logic        left_align;
  } request_t;

  // One character produced by the sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       last;
    logic       truncated;
  } char_beat_t;

  // Convert one hex digit to its ASCII character
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] ofs;
    if (d > 4'd9) begin
      ofs = upper ? CHAR_UPPER_OFS : CHAR_LOWER_OFS;
    end else begin
      ofs = CHAR_ZERO;
    end
    return {4'b0000, d} + ofs;
  endfunction

endpackage

// ===== design/hff_scan.sv =====
// ----------------------------------------------------------------------------
// hff_scan: iterative hex digit counter
// Shifts the value right one nibble per cycle until it is zero and counts
// the steps, giving the number of significant hex digits (zero for zero).
// ----------------------------------------------------------------------------
module hff_scan import hff_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [$clog2((VALUE_BITS+3)/4+1)-1:0] digits
);

  localparam int NIBBLES = (VALUE_BITS + 3) / 4;
  localparam int CW      = $clog2(NIBBLES + 1);

  logic [VALUE_BITS-1:0] shift;
  logic [CW-1:0]         count;
  logic                  busy;

  // Busy flag: set on start, clear once the remainder is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Shift out one nibble per cycle and count it
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= value;
      count <= '0;
    end else if (busy && (shift != '0)) begin
      shift <= shift >> 4;
      count <= count + CW'(1);
    end
  end

  assign done   = busy && (shift == '0);
  assign digits = count;

endmodule

// ===== design/hff_seq.sv =====
// ----------------------------------------------------------------------------
// hff_seq: conversion sequencer
// Latches one request, runs the digit counter, plans the field layout and
// then steps through padding, prefix and digit positions, one character per
// cycle whenever the output slot is free.
// ----------------------------------------------------------------------------
module hff_seq import hff_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  request_t   req,
  output logic       ready,
  input  logic       advance,
  output char_beat_t beat
);

  localparam int NIBBLES = (VALUE_BITS + 3) / 4;
  localparam int CW      = $clog2(NIBBLES + 1);
  localparam int EW      = $clog2(MAX_CHARS + 1);

  phase_t phase, phase_next;

  // Latched request
  logic [VALUE_BITS-1:0] held_value;
  logic                  upper;
  logic                  has_prec;
  logic [5:0]            prec;
  logic [5:0]            width;
  logic                  hash;
  logic                  zpad;
  logic                  left;

  // Layout and progress
  logic [6:0]    size;
  logic [6:0]    positions;
  logic [6:0]    lead_cnt;
  logic          pfx;
  logic [EW-1:0] char_cap;
  logic          trunc;
  logic [5:0]    pos;
  logic [1:0]    spc;
  logic [EW-1:0] emitted;

  // Digit counter
  logic          accept;
  logic [63:0]   v_cut;
  logic          scan_done;
  logic [CW-1:0] ndig;
  logic [6:0]    ndig7;

  assign accept = req_valid && ready;
  assign ndig7  = 7'(ndig);

  // Cut the value to the length mode
  always_comb begin
    unique case (req.length_mode)
      LEN_32:   v_cut = {32'b0, req.value[31:0]};
      LEN_16:   v_cut = {48'b0, req.value[15:0]};
      LEN_8:    v_cut = {56'b0, req.value[7:0]};
      LEN_FULL: v_cut = req.value;
      default:  v_cut = req.value;
    endcase
  end

  hff_scan #(
    .VALUE_BITS(VALUE_BITS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (v_cut[VALUE_BITS-1:0]),
    .done  (scan_done),
    .digits(ndig)
  );

  // Field size from digit count, precision, prefix and zero padding
  logic [6:0] base0, base, size_s1, size_c, positions_c;
  always_comb begin
    base0       = (ndig7 == 7'd0) ? 7'd1 : ndig7;
    base        = (has_prec && ({1'b0, prec} > base0)) ? {1'b0, prec} : base0;
    size_s1     = base + (hash ? 7'd2 : 7'd0);
    size_c      = ((width != 6'd0) && zpad && ({1'b0, width} > size_s1)) ?
                  {1'b0, width} : size_s1;
    positions_c = size_c - (hash ? 7'd2 : 7'd0);
  end

  // Padding, prefix and character total
  logic       prec0;
  logic [6:0] pad_c, lead_c, trail_c, zero_pos;
  logic [8:0] zp9, blank_chars, digit_chars, total_c;
  logic       pfx_c;
  logic [5:0] start_pos;
  always_comb begin
    prec0       = has_prec && (prec == 6'd0);
    pad_c       = ({1'b0, width} > size) ? ({1'b0, width} - size) : 7'd0;
    lead_c      = (!left && !zpad) ? pad_c : 7'd0;
    trail_c     = left ? pad_c : 7'd0;
    pfx_c       = hash && (ndig7 != 7'd0);
    zero_pos    = positions - ndig7;
    zp9         = {2'b00, zero_pos};
    if (width == 6'd0) begin
      blank_chars = 9'd0;
    end else if (hash) begin
      blank_chars = (zp9 << 1) + zp9;
    end else begin
      blank_chars = zp9;
    end
    digit_chars = prec0 ? (9'(ndig7) + blank_chars) : {2'b00, positions};
    total_c     = {2'b00, lead_c} + {2'b00, trail_c} + (pfx_c ? 9'd2 : 9'd0) +
                  digit_chars;
    // Blank positions that give nothing are skipped outright
    start_pos   = (prec0 && (width == 6'd0)) ? 6'(ndig7 - 7'd1) : 6'(positions - 7'd1);
  end

  // Current digit position
  logic [15:0][3:0] nibs;
  logic             rem_zero;
  logic             blank_mode;
  logic [1:0]       spc_last;
  logic             pos_done;
  logic [3:0]       nib;
  logic             is_last;
  always_comb begin
    nibs       = 64'(held_value);
    rem_zero   = ({1'b0, pos} >= ndig7);
    blank_mode = prec0 && rem_zero;
    spc_last   = hash ? 2'd2 : 2'd0;
    pos_done   = !blank_mode || (spc == spc_last);
    nib        = rem_zero ? 4'd0 : nibs[pos[3:0]];
    is_last    = ((emitted + EW'(1)) == char_cap);
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (req_valid) phase_next = PH_SCAN;
      end
      PH_SCAN: begin
        if (scan_done) phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        phase_next = PH_PLAN;
      end
      PH_PLAN: begin
        priority if (total_c == 9'd0) phase_next = PH_IDLE;
        else if (lead_c != 7'd0)      phase_next = PH_LEAD;
        else if (pfx_c)               phase_next = PH_PFX0;
        else                          phase_next = PH_DIGIT;
      end
      PH_LEAD: begin
        if (advance) begin
          priority if (is_last)       phase_next = PH_IDLE;
          else if (lead_cnt == 7'd1)  phase_next = pfx ? PH_PFX0 : PH_DIGIT;
          else                        phase_next = PH_LEAD;
        end
      end
      PH_PFX0: begin
        if (advance) phase_next = is_last ? PH_IDLE : PH_PFX1;
      end
      PH_PFX1: begin
        if (advance) phase_next = is_last ? PH_IDLE : PH_DIGIT;
      end
      PH_DIGIT: begin
        if (advance) begin
          priority if (is_last)                 phase_next = PH_IDLE;
          else if (pos_done && (pos == 6'd0))   phase_next = PH_TRAIL;
          else                                  phase_next = PH_DIGIT;
        end
      end
      PH_TRAIL: begin
        if (advance && is_last) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Handshake and character outputs
  always_comb begin
    ready          = 1'b0;
    beat.valid     = 1'b0;
    beat.code      = CHAR_SPACE;
    beat.last      = is_last;
    beat.truncated = is_last && trunc;
    unique case (phase)
      PH_IDLE: begin
        ready = 1'b1;
      end
      PH_SCAN, PH_SIZE, PH_PLAN: begin
        beat.valid = 1'b0;
      end
      PH_LEAD, PH_TRAIL: begin
        beat.valid = advance;
      end
      PH_PFX0: begin
        beat.valid = advance;
        beat.code  = CHAR_ZERO;
      end
      PH_PFX1: begin
        beat.valid = advance;
        beat.code  = upper ? CHAR_X_UPPER : CHAR_X_LOWER;
      end
      PH_DIGIT: begin
        beat.valid = advance;
        beat.code  = blank_mode ? CHAR_SPACE : hex_char(nib, upper);
      end
      default: beat.valid = 1'b0;
    endcase
  end

  // Hold request, plan layout, advance counters
  always_ff @(posedge clk) begin
    if (accept) begin
      held_value <= v_cut[VALUE_BITS-1:0];
      upper      <= req.uppercase;
      has_prec   <= req.has_precision;
      prec       <= req.precision;
      width      <= req.field_width;
      hash       <= req.hash_prefix;
      zpad       <= req.zero_pad;
      left       <= req.left_align;
      emitted    <= '0;
    end
    if (phase == PH_SIZE) begin
      size      <= size_c;
      positions <= positions_c;
    end
    if (phase == PH_PLAN) begin
      lead_cnt <= lead_c;
      pfx      <= pfx_c;
      trunc    <= (total_c > 9'(MAX_CHARS));
      char_cap <= (total_c > 9'(MAX_CHARS)) ? EW'(MAX_CHARS) : total_c[EW-1:0];
      pos      <= start_pos;
      spc      <= 2'd0;
    end
    if (beat.valid) begin
      emitted <= emitted + EW'(1);
    end
    if ((phase == PH_LEAD) && advance) begin
      lead_cnt <= lead_cnt - 7'd1;
    end
    if ((phase == PH_DIGIT) && advance) begin
      if (pos_done) begin
        spc <= 2'd0;
        pos <= pos - 6'd1;
      end else begin
        spc <= spc + 2'd1;
      end
    end
  end

endmodule

// ===== design/hex_field_formatter.sv =====
// ----------------------------------------------------------------------------
// hex_field_formatter: printf-style %x / %X conversion to a character stream
// Accepts one request per conversion and sends the formatted field, one
// ASCII character per transfer, with tlast on the final character.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. After the transfer in,
// the digit counter shifts the value one nibble per cycle until it is zero,
// the size and plan phases (PH_SIZE, then PH_PLAN) lay out the field, and
// then one character leaves per cycle while the downstream side takes them.
// The block is ready again in the cycle after the final character enters
// the output register. When the field would exceed MAX_CHARS characters
// only the first MAX_CHARS are sent, and the final one carries tuser[0]
// set. A conversion that produces no character sends no transfer.
module hex_field_formatter import hff_pkg::*; #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // value[63:0], length_mode[65:64], uppercase[66], has_precision[67],
  // precision[73:68], field_width[79:74], hash_prefix[80], zero_pad[81],
  // left_align[82], zero fill above
  input  logic [REQ_BYTES*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_char[7:0]
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  // truncated[0]
  output logic [0:0]             m_tuser
);

  request_t   req;
  char_beat_t beat;
  logic       advance;

  // Unpack the request fields
  always_comb begin
    req.value         = s_tdata[63:0];
    req.length_mode   = s_tdata[65:64];
    req.uppercase     = s_tdata[66];
    req.has_precision = s_tdata[67];
    req.precision     = s_tdata[73:68];
    req.field_width   = s_tdata[79:74];
    req.hash_prefix   = s_tdata[80];
    req.zero_pad      = s_tdata[81];
    req.left_align    = s_tdata[82];
  end

  // Step the sequencer whenever the output register can take a character
  assign advance = !m_tvalid || m_tready;

  hff_seq #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_tvalid),
    .req      (req),
    .ready    (s_tready),
    .advance  (advance),
    .beat     (beat)
  );

  // Output register: load a new character, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (beat.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.valid) begin
      m_tdata    <= beat.code;
      m_tlast    <= beat.last;
      m_tuser[0] <= beat.truncated;
    end
  end

endmodule

// ===== bench/tb_hex_field_formatter.sv =====
// ----------------------------------------------------------------------------
// tb_hex_field_formatter: self-checking bench for the hex field formatter
// Sends printf-style %x / %X requests and checks every character transfer
// (code, tlast, truncation flag) against a behavioral formatter kept in the
// bench. Directed corner requests come first, then random ones, with random
// gaps on the request side and random stalls on the character side.
// ----------------------------------------------------------------------------
module tb_hex_field_formatter;
  import hff_pkg::*;

  localparam int MAX_CHARS   = 64;
  localparam int HANG_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 200;
  localparam int RANDOM_REQS = 200;

  typedef struct {
    request_t req;
    int       gap;
  } pending_req_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       cut;
  } char_exp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [REQ_BYTES*8-1:0] s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   m_tlast;
  logic [0:0]             m_tuser;

  pending_req_t req_q[$];
  char_exp_t    char_q[$];
  request_t     cur_req;
  int           err_count = 0;
  int           idle_cycles = 0;
  int           rx_hold = 0;
  int           rx_calm = 0;
  int           tx_calm = 0;

  hex_field_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pause length 0..17, with occasional calm stretches of no pause at all
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic request_t make_req(input logic [63:0] value, input logic [1:0] mode,
                                        input logic upper, input logic has_prec,
                                        input logic [5:0] prec, input logic [5:0] width,
                                        input logic hash, input logic zpad, input logic left);
    request_t r;
    r.value         = value;
    r.length_mode   = mode;
    r.uppercase     = upper;
    r.has_precision = has_prec;
    r.precision     = prec;
    r.field_width   = width;
    r.hash_prefix   = hash;
    r.zero_pad      = zpad;
    r.left_align    = left;
    return r;
  endfunction

  function automatic logic [REQ_BYTES*8-1:0] pack_req(input request_t r);
    return {{(REQ_BYTES*8-REQ_BITS){1'b0}}, r.left_align, r.zero_pad, r.hash_prefix,
            r.field_width, r.precision, r.has_precision, r.uppercase, r.length_mode,
            r.value};
  endfunction

  task automatic add_req(input request_t r);
    pending_req_t p;
    p.req = r;
    p.gap = draw_pause(tx_calm);
    req_q.push_back(p);
  endtask

  // Format one request and queue the characters it should produce
  task automatic format_hex(input request_t r);
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] rem;
    logic [3:0]  d;
    logic [7:0]  text[$];
    int          size;
    int          positions;
    int          prec;
    int          width;
    int          n;
    char_exp_t   e;
    prec  = int'(r.precision);
    width = int'(r.field_width);
    case (r.length_mode)
      LEN_32:  v = {32'd0, r.value[31:0]};
      LEN_16:  v = {48'd0, r.value[15:0]};
      LEN_8:   v = {56'd0, r.value[7:0]};
      default: v = r.value;
    endcase
    // size the field
    size = (v == 0) ? 1 : 0;
    for (t = v; t != 0; t = t >> 4) size++;
    if (r.has_precision && prec > size) size = prec;
    if (r.hash_prefix) size += 2;
    if (width != 0 && r.zero_pad && width > size) size = width;
    // lead spaces, prefix, digit positions, trail spaces
    if (!r.left_align && !r.zero_pad) begin
      for (int k = 0; k < width - size; k++) text.push_back(CHAR_SPACE);
    end
    if (r.hash_prefix && v != 0) begin
      text.push_back(CHAR_ZERO);
      text.push_back(r.uppercase ? CHAR_X_UPPER : CHAR_X_LOWER);
    end
    positions = r.hash_prefix ? size - 2 : size;
    for (int i = positions - 1; i >= 0; i--) begin
      rem = (i >= 16) ? 64'd0 : (v >> (4 * i));
      d   = rem[3:0];
      if (r.has_precision && prec == 0 && rem == 0) begin
        // zero position under explicit zero precision turns into spaces, or nothing when width is 0
        if (width > 0) begin
          for (int k = 0; k < (r.hash_prefix ? 3 : 1); k++) text.push_back(CHAR_SPACE);
        end
      end else if (d > 4'd9) begin
        text.push_back({4'd0, d} + (r.uppercase ? CHAR_UPPER_OFS : CHAR_LOWER_OFS));
      end else begin
        text.push_back({4'd0, d} + CHAR_ZERO);
      end
    end
    if (r.left_align && width > size) begin
      for (int k = 0; k < width - size; k++) text.push_back(CHAR_SPACE);
    end
    // cut at the character limit
    n = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
    for (int k = 0; k < n; k++) begin
      e.code = text[k];
      e.last = (k == n - 1);
      e.cut  = (k == n - 1) && (text.size() > MAX_CHARS);
      char_q.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Request driver
  always @(posedge clk) begin
    pending_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) format_hex(cur_req);
      if (!s_tvalid || s_tready) begin
        if (req_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (req_q[0].gap > 0) begin
          req_q[0].gap--;
          s_tvalid <= 1'b0;
        end else begin
          nxt      = req_q.pop_front();
          cur_req  = nxt.req;
          s_tdata  <= pack_req(cur_req);
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Character monitor and downstream stall
  always @(posedge clk) begin
    char_exp_t got;
    char_exp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tlast, m_tuser[0]};
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b cut=%0b",
                                    got.code, got.last, got.cut));
        end else begin
          want = char_q.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf("char 0x%02h/0x%02h last %0b/%0b cut %0b/%0b (got/exp)",
                                      got.code, want.code, got.last, want.last,
                                      got.cut, want.cut));
          end
        end
        rx_hold = draw_pause(rx_calm);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] val;
    logic [5:0]  prec;
    logic [5:0]  width;
    logic        has_prec;

    // directed corners: extremes, each length mode, zero precision spaces,
    // hash on zero, pad combinations, exact and overflowing character limit
    add_req(make_req(64'd0, LEN_32, 0, 0, 0, 0, 0, 0, 0));
    add_req(make_req('1, LEN_FULL, 0, 0, 0, 0, 0, 0, 0));
    add_req(make_req('1, LEN_FULL, 1, 0, 0, 0, 1, 0, 0));
    add_req(make_req(64'h1234_5678_9abc_def0, LEN_32, 0, 0, 0, 0, 1, 0, 0));
    add_req(make_req(64'h1234_5678_9abc_def0, LEN_16, 1, 0, 0, 0, 0, 0, 0));
    add_req(make_req(64'h1234_5678_9abc_de0f, LEN_8, 0, 0, 0, 0, 0, 0, 0));
    add_req(make_req(64'hffff_ffff_0000_0000, LEN_32, 0, 1, 0, 0, 0, 0, 0));
    add_req(make_req(64'd0, LEN_FULL, 0, 1, 0, 5, 0, 0, 0));
    add_req(make_req(64'd0, LEN_FULL, 0, 1, 0, 5, 1, 0, 0));
    add_req(make_req(64'h1f, LEN_FULL, 1, 1, 0, 8, 0, 1, 0));
    add_req(make_req(64'h1f, LEN_FULL, 0, 1, 0, 9, 1, 1, 1));
    add_req(make_req(64'd0, LEN_32, 1, 0, 0, 6, 1, 0, 0));
    add_req(make_req(64'habc, LEN_16, 0, 0, 0, 10, 0, 1, 1));
    add_req(make_req(64'habc, LEN_16, 1, 0, 0, 12, 1, 0, 1));
    add_req(make_req(64'h5, LEN_8, 0, 1, 32, 0, 0, 0, 0));
    add_req(make_req(64'h5, LEN_8, 1, 1, 62, 0, 1, 0, 0));
    add_req(make_req(64'h5, LEN_8, 1, 1, 63, 0, 1, 0, 0));
    add_req(make_req('1, LEN_FULL, 0, 1, 63, 63, 1, 1, 1));
    add_req(make_req('1, LEN_FULL, 1, 0, 0, 63, 1, 0, 0));
    add_req(make_req(64'd0, LEN_FULL, 0, 1, 0, 63, 1, 1, 0));
    add_req(make_req(64'h8000_0000_0000_0000, LEN_FULL, 1, 1, 20, 40, 0, 1, 0));
    add_req(make_req(64'd7, LEN_32, 0, 0, 0, 63, 0, 0, 1));

    // random requests
    repeat (RANDOM_REQS) begin
      case ($urandom_range(0, 5))
        0:       val = 64'd0;
        1:       val = 64'($urandom_range(0, 15));
        2:       val = {32'd0, $urandom()};
        3:       val = '1;
        default: val = {$urandom(), $urandom()};
      endcase
      has_prec = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0, 1:    prec = 6'd0;
        2:       prec = 6'($urandom_range(33, 63));
        default: prec = 6'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 7))
        0, 1:    width = 6'd0;
        2:       width = 6'($urandom_range(33, 63));
        default: width = 6'($urandom_range(1, 32));
      endcase
      add_req(make_req(val, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), has_prec,
                       prec, width, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1))));
    end

    // reset
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // drain: all requests taken, all characters seen, then let the block settle
    while (req_q.size() != 0 || s_tvalid) @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hff_pkg.sv
design/hff_scan.sv
design/hff_seq.sv
design/hex_field_formatter.sv
bench/tb_hex_field_formatter.sv
